// ----- rtl/core/bilinear_image_scaler_unit_assert.svh -----
// assertion macros for the bilinear scaler
`ifndef BILINEAR_IMAGE_SCALER_UNIT_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define BIS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BIS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/bis_pkg.sv -----
package bis_pkg;
    localparam int MaxSrcWidth  = 1024;
    localparam int MaxSrcHeight = 1024;
    localparam int FracBits     = 16;
    localparam int CoordW       = 11;
    localparam int ScaleW       = 24;
    localparam int ChanW        = 8;
    localparam int PixW         = 24;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_INV_SCALE  = 2'd2
    } reg_index_t;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic       store;
        logic       map;
        logic       rd;
        logic [1:0] rd_sel;
        logic       cap;
        logic [1:0] cap_sel;
        logic       blend;
        logic       out_load;
    } bis_cmd_t;
endpackage

// ----- rtl/core/bis_ctrl.sv -----
module bis_ctrl
    import bis_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     opcode,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output bis_cmd_t cmd
);
    typedef enum logic [3:0] {
        S_IDLE, S_MAP, S_R0, S_R1, S_R2, S_R3, S_C3, S_BLEND, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_xfer;
    logic   out_xfer;

    assign out_xfer = out_valid_reg && !out_stall;
    // a new request may enter only once the output register is free
    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && !out_xfer);
    assign in_xfer  = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_xfer;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (opcode == OP_STORE)
                        cmd.store = 1'b1;
                    else
                    begin
                        cmd.map    = 1'b1;
                        state_next = S_MAP;
                    end
                end
            end
            S_MAP:
            begin
                cmd.rd = 1'b1; cmd.rd_sel = 2'd0; state_next = S_R0;
            end
            S_R0:
            begin
                cmd.rd = 1'b1; cmd.rd_sel = 2'd1;
                cmd.cap = 1'b1; cmd.cap_sel = 2'd0; state_next = S_R1;
            end
            S_R1:
            begin
                cmd.rd = 1'b1; cmd.rd_sel = 2'd2;
                cmd.cap = 1'b1; cmd.cap_sel = 2'd1; state_next = S_R2;
            end
            S_R2:
            begin
                cmd.rd = 1'b1; cmd.rd_sel = 2'd3;
                cmd.cap = 1'b1; cmd.cap_sel = 2'd2; state_next = S_R3;
            end
            S_R3:
            begin
                cmd.cap = 1'b1; cmd.cap_sel = 2'd3; state_next = S_C3;
            end
            S_C3:
            begin
                cmd.blend = 1'b1; state_next = S_BLEND;
            end
            S_BLEND:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- rtl/core/bis_datapath.sv -----
module bis_datapath
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = MaxSrcWidth,
    parameter int MAX_SRC_HEIGHT = MaxSrcHeight,
    parameter int FRAC_BITS      = FracBits
)
(
    input  logic              clk,
    input  bis_cmd_t          cmd,
    input  logic [CoordW-1:0] pixel_x,
    input  logic [CoordW-1:0] pixel_y,
    input  logic [ChanW-1:0]  in_red,
    input  logic [ChanW-1:0]  in_green,
    input  logic [ChanW-1:0]  in_blue,
    input  logic [CoordW-1:0] src_width,
    input  logic [CoordW-1:0] src_height,
    input  logic [ScaleW-1:0] inverse_scale,
    output logic [ChanW-1:0]  out_red,
    output logic [ChanW-1:0]  out_green,
    output logic [ChanW-1:0]  out_blue
);
    localparam int XW    = $clog2(MAX_SRC_WIDTH);
    localparam int YW    = $clog2(MAX_SRC_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int Depth = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int WS    = FRAC_BITS + 1;
    localparam int TW    = CoordW + 1 + ScaleW + 1;
    localparam int KW    = TW - WS;
    localparam int PW    = WS + 1 + ChanW;      // one axis product
    localparam int SW    = 2 * WS + 2 + ChanW;  // full blended sum
    localparam int XCW   = XW + 1;
    localparam int YCW   = YW + 1;
    localparam int NW    = ((XCW > YCW) ? XCW : YCW) + 1;

    logic [PixW-1:0] mem [Depth];
    logic [PixW-1:0] rd_data_reg;

    logic [XW-1:0] x0_reg, x1_reg;
    logic [YW-1:0] y0_reg, y1_reg;
    logic [WS:0]   fx_reg, fy_reg;
    logic [PixW-1:0] pix_reg [4];
    logic [SW-1:0] sum_reg [3];
    logic [ChanW-1:0] out_reg [3];

    // clamp a size register to 1..max
    function automatic logic [NW-1:0] clamp_n(input logic [CoordW-1:0] v,
                                              input int mx);
        logic [NW-1:0] r;
        if (v == '0) r = NW'(1);
        else if (int'(v) > mx) r = NW'(mx);
        else r = NW'(v);
        return r;
    endfunction

    logic [TW-1:0] tx, ty;
    logic [KW-1:0] kx, ky;
    logic [NW-1:0] wn, hn;
    logic [XW-1:0] x0_n, x1_n;
    logic [YW-1:0] y0_n, y1_n;
    logic [WS:0]   fx_n, fy_n;

    always_comb
    begin
        tx = (TW)'({pixel_x, 1'b1}) * (TW)'(inverse_scale) + ((TW)'(1) << FRAC_BITS);
        ty = (TW)'({pixel_y, 1'b1}) * (TW)'(inverse_scale) + ((TW)'(1) << FRAC_BITS);
        kx = tx[TW-1:WS];
        ky = ty[TW-1:WS];
        wn = clamp_n(src_width, MAX_SRC_WIDTH);
        hn = clamp_n(src_height, MAX_SRC_HEIGHT);
        if (kx == '0)
        begin
            x0_n = '0; x1_n = '0; fx_n = '0;
        end
        else if ((KW+NW)'(kx) >= (KW+NW)'(wn))
        begin
            x0_n = XW'(wn - 1'b1); x1_n = x0_n; fx_n = '0;
        end
        else
        begin
            x0_n = XW'(kx - 1'b1); x1_n = XW'(kx); fx_n = (WS+1)'(tx[WS-1:0]);
        end
        if (ky == '0)
        begin
            y0_n = '0; y1_n = '0; fy_n = '0;
        end
        else if ((KW+NW)'(ky) >= (KW+NW)'(hn))
        begin
            y0_n = YW'(hn - 1'b1); y1_n = y0_n; fy_n = '0;
        end
        else
        begin
            y0_n = YW'(ky - 1'b1); y1_n = YW'(ky); fy_n = (WS+1)'(ty[WS-1:0]);
        end
    end

    logic [AW-1:0] rd_addr;
    always_comb
    begin
        case (cmd.rd_sel)
            2'd0: rd_addr = {y0_reg, x0_reg};
            2'd1: rd_addr = {y0_reg, x1_reg};
            2'd2: rd_addr = {y1_reg, x0_reg};
            default: rd_addr = {y1_reg, x1_reg};
        endcase
    end

    logic store_ok;
    assign store_ok = (int'(pixel_x) < MAX_SRC_WIDTH) && (int'(pixel_y) < MAX_SRC_HEIGHT);

    always_ff @(posedge clk)
    begin
        if (cmd.store && store_ok)
            mem[{pixel_y[YW-1:0], pixel_x[XW-1:0]}] <= {in_red, in_green, in_blue};
        if (cmd.rd)
            rd_data_reg <= mem[rd_addr];
    end

    // blend: one channel sum per lane, weights registered first
    logic [WS:0] gx, gy;
    assign gx = (WS+1)'(1) << WS;
    assign gy = (WS+1)'(1) << WS;

    logic [PW-1:0] col0_reg [3];
    logic [PW-1:0] col1_reg [3];
    logic [WS:0]   fxb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.map)
        begin
            x0_reg <= x0_n; x1_reg <= x1_n; fx_reg <= fx_n;
            y0_reg <= y0_n; y1_reg <= y1_n; fy_reg <= fy_n;
        end
        if (cmd.cap)
            pix_reg[cmd.cap_sel] <= rd_data_reg;
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.blend)
            begin
                col0_reg[c] <= (gy - fy_reg) * pix_reg[0][16-8*c +: ChanW]
                               + fy_reg * pix_reg[2][16-8*c +: ChanW];
                col1_reg[c] <= (gy - fy_reg) * pix_reg[1][16-8*c +: ChanW]
                               + fy_reg * pix_reg[3][16-8*c +: ChanW];
            end
            sum_reg[c] <= (gx - fxb_reg) * col0_reg[c] + fxb_reg * col1_reg[c]
                          + ((SW)'(1) << (2*WS-1));
        end
        if (cmd.blend)
            fxb_reg <= fx_reg;
        if (cmd.out_load)
            for (int c = 0; c < 3; c++)
                out_reg[c] <= (|sum_reg[c][SW-1:2*WS+ChanW]) ? '1
                              : sum_reg[c][2*WS +: ChanW];
    end

    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
endmodule

// ----- rtl/core/bis_cfg_regs.sv -----
module bis_cfg_regs
    import bis_pkg::*;
#(
    parameter int FRAC_BITS = FracBits
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [ScaleW-1:0] cfg_data,
    output logic [CoordW-1:0] src_width,
    output logic [CoordW-1:0] src_height,
    output logic [ScaleW-1:0] inverse_scale
);
    logic [CoordW-1:0] width_reg, height_reg;
    logic [ScaleW-1:0] scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CoordW'(640);
            height_reg <= CoordW'(640);
            scale_reg  <= ScaleW'(1) << FRAC_BITS;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  width_reg  <= cfg_data[CoordW-1:0];
                REG_SRC_HEIGHT: height_reg <= cfg_data[CoordW-1:0];
                REG_INV_SCALE:  scale_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign src_width     = width_reg;
    assign src_height    = height_reg;
    assign inverse_scale = scale_reg;
endmodule

// ----- rtl/core/bilinear_image_scaler_unit.sv -----
// channel  | handshake            | payload
// in       | in_valid / in_stall  | opcode pixel_x pixel_y in_red in_green in_blue
// out      | out_valid / out_stall| out_red out_green out_blue
// cfg      | cfg_write            | cfg_index cfg_data
// a store is written on transfer; a request steps through MAP, R0..R3, C3, BLEND and OUT
// before its result: four reads on the single frame memory port plus the blend stages
// the frame memory has no reset; rst_n clears the controller and the config registers
// a stalled result is held and blocks the next item until it transfers
`include "bilinear_image_scaler_unit_assert.svh"
module bilinear_image_scaler_unit
    import bis_pkg::*;
#(
    parameter int MAX_SRC_WIDTH  = MaxSrcWidth,
    parameter int MAX_SRC_HEIGHT = MaxSrcHeight,
    parameter int FRAC_BITS      = FracBits
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [CoordW-1:0] pixel_x,
    input  logic [CoordW-1:0] pixel_y,
    input  logic [ChanW-1:0]  in_red,
    input  logic [ChanW-1:0]  in_green,
    input  logic [ChanW-1:0]  in_blue,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ChanW-1:0]  out_red,
    output logic [ChanW-1:0]  out_green,
    output logic [ChanW-1:0]  out_blue,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [ScaleW-1:0] cfg_data
);
    bis_cmd_t          cmd;
    logic [CoordW-1:0] src_width, src_height;
    logic [ScaleW-1:0] inverse_scale;

    bis_cfg_regs #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cfg (
        .clk, .rst_n, .cfg_write, .cfg_index, .cfg_data,
        .src_width, .src_height, .inverse_scale
    );

    bis_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .opcode, .in_stall,
        .out_valid, .out_stall, .cmd
    );

    bis_datapath #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT),
        .FRAC_BITS(FRAC_BITS)
    ) u_dp (
        .clk, .cmd, .pixel_x, .pixel_y, .in_red, .in_green, .in_blue,
        .src_width, .src_height, .inverse_scale,
        .out_red, .out_green, .out_blue
    );

    `BIS_ASSERT_NEXT(a_req_busy, clk, rst_n, cmd.map, in_stall, "request not blocking input")
    `BIS_ASSERT_NEXT(a_out_set, clk, rst_n, cmd.out_load, out_valid, "result not presented")
    `BIS_ASSERT_IMPL(a_one_cmd, clk, rst_n, cmd.store, !cmd.rd && !cmd.blend, "store overlaps request")
endmodule
